// ----- rtl/acl_pkg.sv -----
// ----------------------------------------------------------------------------
// acl_pkg
// shared constants, result type and arctangent table for the arc core
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NIT          = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  // two rotations per cordic stage
  localparam int CST          = (NIT + 1) / 2;

  // square root: iterations per stage and number of stages
  localparam int SQ_PER = 4;
  localparam int SQ_STG = 32 / SQ_PER;

  localparam int LEN_LAT = SQ_STG + 4;
  localparam int PT_LAT  = CST + 4;
  localparam int LAT     = (LEN_LAT > PT_LAT) ? LEN_LAT : PT_LAT;

  localparam int LEN_W     = 35;
  localparam int IN_W      = 272;
  localparam int IN_USER_W = 3;
  localparam int OUT_W     = 136;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ok;
  } pt_res_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [35:0] atan_q30(input int i);
    logic signed [35:0] v;
    case (i)
      0:  v = 36'sd843314857;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043837;
      3:  v = 36'sd133525159;
      4:  v = 36'sd67021687;
      5:  v = 36'sd33543516;
      6:  v = 36'sd16775851;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194283;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048576;
      11: v = 36'sd524288;
      12: v = 36'sd262144;
      13: v = 36'sd131072;
      14: v = 36'sd65536;
      15: v = 36'sd32768;
      16: v = 36'sd16384;
      17: v = 36'sd8192;
      18: v = 36'sd4096;
      19: v = 36'sd2048;
      20: v = 36'sd1024;
      21: v = 36'sd512;
      22: v = 36'sd256;
      23: v = 36'sd128;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/acl_len.sv -----
// ----------------------------------------------------------------------------
// acl_len
// radius by pipelined integer square root, then rounded saturating arc length
// ----------------------------------------------------------------------------
module acl_len (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [31:0]         axis_x_i,
  input  logic signed [31:0]         axis_y_i,
  input  logic signed [31:0]         axis_z_i,
  input  logic [18:0]                sweep_angle_i,
  input  logic                       is_bounded_i,
  output logic [acl_pkg::LEN_W-1:0]  arc_length_o
);
  import acl_pkg::*;

  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  function automatic sq_t sq_iter(input sq_t s, input int j);
    sq_t         o;
    logic [63:0] bit_v;
    logic [63:0] trial;
    bit_v = 64'd1 << (62 - 2 * j);
    trial = s.root + bit_v;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + bit_v;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  logic [31:0] mag [3];
  logic [63:0] sqr_q [3];
  logic [18:0] k1_q, k2_q;
  logic [63:0] sum_q;
  sq_t         sq_q [SQ_STG];
  logic [18:0] ks_q [SQ_STG];
  logic [50:0] prod_q;
  logic [51:0] rsum;
  logic [LEN_W-1:0] len_q;

  assign mag[0] = axis_x_i[31] ? 32'(-axis_x_i) : 32'(axis_x_i);
  assign mag[1] = axis_y_i[31] ? 32'(-axis_y_i) : 32'(axis_y_i);
  assign mag[2] = axis_z_i[31] ? 32'(-axis_z_i) : 32'(axis_z_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sqr_q[i] <= 64'(mag[i]) * 64'(mag[i]);
      k1_q  <= is_bounded_i ? sweep_angle_i : TWO_PI_Q16;
      sum_q <= sqr_q[0] + sqr_q[1] + sqr_q[2];
      k2_q  <= k1_q;
    end
  end

  for (genvar s = 0; s < SQ_STG; s++) begin : g_sq
    sq_t st_in;
    sq_t st_out;
    always_comb begin
      if (s == 0) begin
        st_in.rem  = sum_q;
        st_in.root = 64'd0;
      end else begin
        st_in = sq_q[(s == 0) ? 0 : s - 1];
      end
      st_out = st_in;
      for (int j = 0; j < SQ_PER; j++) st_out = sq_iter(st_out, s * SQ_PER + j);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[s] <= st_out;
        ks_q[s] <= (s == 0) ? k2_q : ks_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign rsum = {1'b0, prod_q} + 52'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 51'(sq_q[SQ_STG-1].root[31:0]) * 51'(ks_q[SQ_STG-1]);
      len_q  <= rsum[51] ? {LEN_W{1'b1}} : rsum[50:16];
    end
  end

  assign arc_length_o = len_q;

endmodule

// ----- rtl/acl_pt.sv -----
// ----------------------------------------------------------------------------
// acl_pt
// start or end point: cordic sine and cosine with rodrigues rotation
// ----------------------------------------------------------------------------
module acl_pt (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic signed [17:0] normal_x_i,
  input  logic signed [17:0] normal_y_i,
  input  logic signed [17:0] normal_z_i,
  input  logic [18:0]        sweep_angle_i,
  input  logic               is_bounded_i,
  input  logic [1:0]         point_index_i,
  output acl_pkg::pt_res_t   res_o
);
  import acl_pkg::*;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [27:0] ONE_Q24     = 28'sd16777216;

  typedef struct {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [35:0] t;
    logic               neg;
    logic signed [17:0] n  [3];
    logic signed [34:0] u  [3];
    logic signed [53:0] wd [3];
    logic signed [37:0] w  [3];
    logic signed [32:0] ca [3];
    logic               ok;
    logic               sel;
  } cs_t;

  logic signed [31:0] c_in [3];
  logic signed [31:0] a_in [3];
  logic signed [17:0] n_in [3];
  logic signed [35:0] t_red;
  logic               neg_red;

  // first stage: angle fold, n x a partial products, center plus axis
  logic signed [35:0] t0_q;
  logic               neg0_q;
  logic signed [49:0] pa_q [3];
  logic signed [49:0] pb_q [3];
  logic signed [17:0] n0_q [3];
  logic signed [32:0] ca0_q [3];
  logic               ok0_q, sel0_q;

  cs_t cs_q [CST];

  // post cordic
  logic signed [27:0] s24_q, omc_q;
  logic signed [34:0] ua_q [3];
  logic signed [37:0] wa_q [3];
  logic signed [32:0] caa_q [3];
  logic               oka_q, sela_q;
  logic signed [65:0] t1_q [3];
  logic signed [65:0] t2_q [3];
  logic signed [32:0] cab_q [3];
  logic               okb_q, selb_q;
  logic signed [27:0] c24, s24;
  logic signed [31:0] p_sat [3];
  pt_res_t            res_q;

  assign c_in = '{center_x_i, center_y_i, center_z_i};
  assign a_in = '{axis_x_i, axis_y_i, axis_z_i};
  assign n_in = '{normal_x_i, normal_y_i, normal_z_i};

  always_comb begin
    t_red   = $signed({3'b000, sweep_angle_i, 14'd0});
    neg_red = 1'b0;
    if (t_red > PI_Q30) t_red = t_red - (PI_Q30 <<< 1);
    if (t_red > HALF_PI_Q30) begin
      t_red   = t_red - PI_Q30;
      neg_red = 1'b1;
    end else if (t_red < -HALF_PI_Q30) begin
      t_red   = t_red + PI_Q30;
      neg_red = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q   <= t_red;
      neg0_q <= neg_red;
      for (int k = 0; k < 3; k++) begin
        pa_q[k]  <= 50'(n_in[(k + 1) % 3]) * 50'(a_in[(k + 2) % 3]);
        pb_q[k]  <= 50'(n_in[(k + 2) % 3]) * 50'(a_in[(k + 1) % 3]);
        n0_q[k]  <= n_in[k];
        ca0_q[k] <= 33'(c_in[k]) + 33'(a_in[k]);
      end
      ok0_q  <= is_bounded_i && (point_index_i[1] == 1'b0);
      sel0_q <= point_index_i[0];
    end
  end

  for (genvar s = 0; s < CST; s++) begin : g_cord
    cs_t                ci;
    cs_t                co;
    logic signed [51:0] ud [3];
    logic signed [33:0] dx, dy;
    always_comb begin
      if (s == 0) begin
        ci = cs_q[0];
        ci.x   = GAIN_Q30;
        ci.y   = 34'sd0;
        ci.t   = t0_q;
        ci.neg = neg0_q;
        ci.n   = n0_q;
        ci.ca  = ca0_q;
        ci.ok  = ok0_q;
        ci.sel = sel0_q;
      end else begin
        ci = cs_q[(s == 0) ? 0 : s - 1];
      end
      co = ci;
      for (int k = 0; k < 3; k++) begin
        ud[k] = 52'(pa_q[k]) - 52'(pb_q[k]) + 52'sd32768;
        if (s == 0) co.u[k] = 35'(ud[k] >>> 16);
        if (s == 1) co.wd[k] = 54'(ci.n[(k + 1) % 3]) * 54'(ci.u[(k + 2) % 3])
                             - 54'(ci.n[(k + 2) % 3]) * 54'(ci.u[(k + 1) % 3]);
        if (s == 2) co.w[k] = 38'((ci.wd[k] + 54'sd32768) >>> 16);
      end
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < NIT) begin
          dx = co.y >>> (2 * s + j);
          dy = co.x >>> (2 * s + j);
          if (co.t >= 0) begin
            co.x = co.x - dx;
            co.y = co.y + dy;
            co.t = co.t - atan_q30(2 * s + j);
          end else begin
            co.x = co.x + dx;
            co.y = co.y - dy;
            co.t = co.t + atan_q30(2 * s + j);
          end
        end else begin
          dx = 34'sd0;
          dy = 34'sd0;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) cs_q[s] <= co;
    end
  end

  always_comb begin
    logic signed [33:0] xf, yf;
    xf  = cs_q[CST-1].neg ? -cs_q[CST-1].x : cs_q[CST-1].x;
    yf  = cs_q[CST-1].neg ? -cs_q[CST-1].y : cs_q[CST-1].y;
    c24 = 28'((xf + 34'sd32) >>> 6);
    s24 = 28'((yf + 34'sd32) >>> 6);
  end

  always_comb begin
    logic signed [41:0] r1, r2;
    logic signed [43:0] full;
    for (int k = 0; k < 3; k++) begin
      r1   = 42'((t1_q[k] + 66'sd8388608) >>> 24);
      r2   = 42'((t2_q[k] + 66'sd8388608) >>> 24);
      full = selb_q ? 44'(cab_q[k]) + 44'(r1) + 44'(r2) : 44'(cab_q[k]);
      if (full > 44'sd2147483647)       p_sat[k] = 32'sh7fffffff;
      else if (full < -44'sd2147483648) p_sat[k] = 32'sh80000000;
      else                              p_sat[k] = 32'(full);
      if (!okb_q) p_sat[k] = 32'sd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s24_q  <= s24;
      omc_q  <= ONE_Q24 - c24;
      ua_q   <= cs_q[CST-1].u;
      wa_q   <= cs_q[CST-1].w;
      caa_q  <= cs_q[CST-1].ca;
      oka_q  <= cs_q[CST-1].ok;
      sela_q <= cs_q[CST-1].sel;
      for (int k = 0; k < 3; k++) begin
        t1_q[k] <= 66'(s24_q) * 66'(ua_q[k]);
        t2_q[k] <= 66'(omc_q) * 66'(wa_q[k]);
      end
      cab_q    <= caa_q;
      okb_q    <= oka_q;
      selb_q   <= sela_q;
      res_q.x  <= p_sat[0];
      res_q.y  <= p_sat[1];
      res_q.z  <= p_sat[2];
      res_q.ok <= okb_q;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/arc_length_and_endpoint_core.sv -----
// ----------------------------------------------------------------------------
// arc_length_and_endpoint_core
// arc length and start or end point of a circular arc in 3d, fully pipelined
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: center xyz, axis xyz, normal xyz, sweep; tuser: flags
// m_axis    out  tdata: arc_length, point xyz; tuser: point_valid
//
// one item per cycle while the output is not stalled; the longer of the square root
// and cordic chains sets the pipeline depth, and the shorter path is padded to match
// reset clears only the valid bits; payload registers are left as they are
// the whole pipeline freezes while the output holds an item not yet taken
// ----------------------------------------------------------------------------
module arc_length_and_endpoint_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // center_x, center_y, center_z, axis_x, axis_y, axis_z,
  // normal_x, normal_y, normal_z, sweep_angle, zero fill
  input  logic [acl_pkg::IN_W-1:0]          s_axis_tdata_i,
  // is_bounded, point_index
  input  logic [acl_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // arc_length, point_x, point_y, point_z, zero fill
  output logic [acl_pkg::OUT_W-1:0]         m_axis_tdata_o,
  // point_valid
  output logic [0:0]                        m_axis_tuser_o
);
  import acl_pkg::*;

  localparam int LEN_PAD = LAT - LEN_LAT;
  localparam int PT_PAD  = LAT - PT_LAT;

  logic             en;
  logic [LAT-1:0]   vld_q;
  logic [LEN_W-1:0] len_raw, len_out;
  pt_res_t          pt_raw, pt_out;

  // pipeline advances unless the output item is stalled
  assign en              = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  acl_len u_len (
    .clk_i         (clk_i),
    .en_i          (en),
    .axis_x_i      ($signed(s_axis_tdata_i[127:96])),
    .axis_y_i      ($signed(s_axis_tdata_i[159:128])),
    .axis_z_i      ($signed(s_axis_tdata_i[191:160])),
    .sweep_angle_i (s_axis_tdata_i[264:246]),
    .is_bounded_i  (s_axis_tuser_i[0]),
    .arc_length_o  (len_raw)
  );

  acl_pt u_pt (
    .clk_i         (clk_i),
    .en_i          (en),
    .center_x_i    ($signed(s_axis_tdata_i[31:0])),
    .center_y_i    ($signed(s_axis_tdata_i[63:32])),
    .center_z_i    ($signed(s_axis_tdata_i[95:64])),
    .axis_x_i      ($signed(s_axis_tdata_i[127:96])),
    .axis_y_i      ($signed(s_axis_tdata_i[159:128])),
    .axis_z_i      ($signed(s_axis_tdata_i[191:160])),
    .normal_x_i    ($signed(s_axis_tdata_i[209:192])),
    .normal_y_i    ($signed(s_axis_tdata_i[227:210])),
    .normal_z_i    ($signed(s_axis_tdata_i[245:228])),
    .sweep_angle_i (s_axis_tdata_i[264:246]),
    .is_bounded_i  (s_axis_tuser_i[0]),
    .point_index_i (s_axis_tuser_i[2:1]),
    .res_o         (pt_raw)
  );

  // align the shorter path to the common latency
  if (LEN_PAD > 0) begin : g_len_pad
    logic [LEN_W-1:0] dly_q [LEN_PAD];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dly_q[0] <= len_raw;
        for (int i = 1; i < LEN_PAD; i++) dly_q[i] <= dly_q[i-1];
      end
    end
    assign len_out = dly_q[LEN_PAD-1];
  end else begin : g_len_nopad
    assign len_out = len_raw;
  end

  if (PT_PAD > 0) begin : g_pt_pad
    pt_res_t dly_q [PT_PAD];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dly_q[0] <= pt_raw;
        for (int i = 1; i < PT_PAD; i++) dly_q[i] <= dly_q[i-1];
      end
    end
    assign pt_out = dly_q[PT_PAD-1];
  end else begin : g_pt_nopad
    assign pt_out = pt_raw;
  end

  assign m_axis_tvalid_o = vld_q[LAT-1];
  assign m_axis_tdata_o  = {5'd0, pt_out.z, pt_out.y, pt_out.x, len_out};
  assign m_axis_tuser_o  = pt_out.ok;

endmodule

// ----- rtl/acl_chk.sv -----
// ----------------------------------------------------------------------------
// acl_chk
// port level checks for the arc core, bound to its top level
// ----------------------------------------------------------------------------
module acl_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [acl_pkg::OUT_W-1:0]     m_axis_tdata_o,
  input logic [0:0]                    m_axis_tuser_o
);
  import acl_pkg::*;

  // invalid point reads as zero
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[130:35] == 96'd0)
    else $error("invalid point not zero");

  // input side never blocked by an empty or draining output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("ready does not follow output state");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind arc_length_and_endpoint_core acl_chk u_acl_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
